### src/m32k_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// m32k_pkg
// Shared types and constants for the Matern 3/2 kernel evaluator.
// ---------------------------------------------------------------------------
package m32k_pkg;

  // Default number of fraction bits of coordinates and lengthscales.
  localparam int FRAC_BITS_DEF = 16;

  // e^-1 in Q32.
  localparam logic [31:0] EXP_M1_Q32 = 32'd1580030169;

  // Taylor series length for exp(-frac).
  localparam logic [3:0] TAYLOR_TERMS = 4'd14;

  // Distances at or above this integer part give a kernel value of zero.
  localparam int T_LIMIT_INT = 32;

  // Kernel value of 1.0 in Q1.16.
  localparam logic [16:0] KVAL_ONE = 17'd65536;

  // One finished pair handed from the front to the back.
  typedef struct packed {
    logic [63:0] acc;
    logic        sat;
  } pair_t;

endpackage

### src/m32k_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// m32k_front
// Accepts coordinate items and accumulates the saturating squared distance.
// ---------------------------------------------------------------------------
module m32k_front import m32k_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [31:0] coord_a,
  input  logic [31:0] coord_b,
  input  logic [23:0] inv_lengthscale,
  input  logic        last_dim,
  output logic        q_push,
  output pair_t       q_data,
  input  logic        q_full
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_SQR, S_ACC} state_t;

  state_t      state;
  logic [32:0] mag;
  logic [23:0] inv;
  logic        last;
  logic [55:0] prod;
  logic [63:0] sq;
  logic [63:0] acc;
  logic        sat;
  logic        sq_sat;

  logic signed [32:0] diff;
  logic [55:0]        s_full;
  logic [64:0]        sum;
  logic [63:0]        acc_next;
  logic               sat_next;

  // Signed difference of the two coordinates and its magnitude.
  assign diff = {coord_a[31], coord_a} - {coord_b[31], coord_b};

  // Scaled difference, truncated to the coordinate format.
  assign s_full = prod >> FRAC_BITS;

  // Saturating accumulation of the squared term.
  assign sum      = {1'b0, acc} + {1'b0, sq};
  assign acc_next = sum[64] ? {64{1'b1}} : sum[63:0];
  assign sat_next = sat | sq_sat | sum[64];

  assign full   = (state != S_IDLE);
  assign q_push = (state == S_ACC) && last && !q_full;
  assign q_data = '{acc: acc_next, sat: sat_next};

  // Sequencer for one item: multiply, square, accumulate.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      acc   <= '0;
      sat   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (push) begin
            mag   <= diff[32] ? 33'(-diff) : 33'(diff);
            inv   <= inv_lengthscale;
            last  <= last_dim;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= 56'(mag[31:0] * inv);
          state <= S_SQR;
        end
        S_SQR: begin
          sq_sat <= |s_full[55:32];
          sq     <= (|s_full[55:32]) ? {64{1'b1}} : 64'(s_full[31:0] * s_full[31:0]);
          state  <= S_ACC;
        end
        S_ACC: begin
          if (!last) begin
            acc   <= acc_next;
            sat   <= sat_next;
            state <= S_IDLE;
          end else if (!q_full) begin
            acc   <= '0;
            sat   <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### src/m32k_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// m32k_queue
// Two-entry queue of finished pair sums between front and back.
// ---------------------------------------------------------------------------
module m32k_queue import m32k_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr,
  input  pair_t wr_data,
  output logic  q_full,
  input  logic  rd,
  output pair_t rd_data,
  output logic  q_empty
);

  pair_t      mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign q_full  = (count == 2'd2);
  assign q_empty = (count == 2'd0);
  assign rd_data = mem[rptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (wr && !q_full) begin
      mem[wptr] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (wr && !q_full) begin
        wptr <= ~wptr;
      end
      if (rd && !q_empty) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(wr && !q_full) - 2'(rd && !q_empty);
    end
  end

endmodule

### src/m32k_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// m32k_back
// Turns a squared distance into the kernel value: square root, exp series,
// e^-1 multiplies and final product, one pair at a time.
// ---------------------------------------------------------------------------
module m32k_back import m32k_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  pair_t       q_data,
  output logic        q_pop,
  output logic        empty,
  input  logic        pop,
  output logic [16:0] kernel_value,
  output logic        saturated
);

  typedef enum logic [3:0] {
    S_IDLE, S_SQRT, S_CHK, S_TMUL, S_TDIV, S_TSUM, S_EXPM, S_FIN1, S_FIN2, S_FIN3,
    S_DONE
  } state_t;

  state_t             state;
  logic               sat;
  logic [63:0]        rem;
  logic [63:0]        res;
  logic [63:0]        bitv;
  logic [4:0]         ip;
  logic [31:0]        x;
  logic [32:0]        term;
  logic signed [35:0] sum;
  logic [3:0]         k;
  logic [32:0]        dvd;
  logic [67:0]        qprod;
  logic [5:0]         cnt;
  logic [32:0]        g;
  logic [38:0]        p1;
  logic [32:0]        p2;
  logic [16:0]        kval;
  logic               out_valid;

  logic [65:0] acc3;
  logic [63:0] res_bit;
  logic [31:0] t;
  logic [63:0] t32;
  logic [64:0] tprod;
  logic [32:0] quo;
  logic [39:0] fsum;
  logic [23:0] val;

  // Reciprocal of the term index, ceil(2^36 / k). Exact floor division of
  // any 32-bit dividend by k for every index of the series.
  function automatic logic [35:0] recip_of(logic [3:0] kk);
    logic [35:0] m;
    unique case (kk)
      4'd2:    m = 36'd34359738368;
      4'd3:    m = 36'd22906492246;
      4'd4:    m = 36'd17179869184;
      4'd5:    m = 36'd13743895348;
      4'd6:    m = 36'd11453246123;
      4'd7:    m = 36'd9817068106;
      4'd8:    m = 36'd8589934592;
      4'd9:    m = 36'd7635497416;
      4'd10:   m = 36'd6871947674;
      4'd11:   m = 36'd6247225158;
      4'd12:   m = 36'd5726623062;
      4'd13:   m = 36'd5286113596;
      default: m = '0;
    endcase
    return m;
  endfunction

  // Saturating 3 * sum for the square root input.
  assign acc3    = {2'b00, q_data.acc} + {1'b0, q_data.acc, 1'b0};
  assign res_bit = res + bitv;

  // Root and its fixed-point forms.
  assign t   = res[31:0];
  assign t32 = {32'd0, t} << (32 - FRAC_BITS);

  assign tprod = 65'(term * x);

  // Quotient of the term by its index; the first index divides by one.
  assign quo = (k == 4'd1) ? dvd : {1'b0, qprod[67:36]};

  // Final combine of the two partial products.
  assign fsum = {1'b0, p1} + {7'd0, p2};
  assign val  = fsum[39:16];

  assign q_pop        = (state == S_IDLE) && !q_empty;
  assign empty        = !out_valid;

  // Kernel sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_DONE) && (!out_valid || pop)) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            sat   <= q_data.sat;
            rem   <= (|acc3[65:64]) ? {64{1'b1}} : acc3[63:0];
            res   <= '0;
            bitv  <= 64'd1 << 62;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (rem >= res_bit) begin
            rem <= rem - res_bit;
            res <= (res >> 1) + bitv;
          end else begin
            res <= res >> 1;
          end
          bitv <= bitv >> 2;
          if (bitv[0]) begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if ((t >> FRAC_BITS) >= 32'(T_LIMIT_INT)) begin
            kval  <= '0;
            state <= S_DONE;
          end else begin
            ip    <= t32[36:32];
            x     <= t32[31:0];
            term  <= 33'h1_0000_0000;
            sum   <= 36'sh1_0000_0000;
            k     <= 4'd1;
            state <= S_TMUL;
          end
        end
        S_TMUL: begin
          dvd   <= tprod[64:32];
          state <= S_TDIV;
        end
        S_TDIV: begin
          qprod <= 68'(dvd[31:0] * recip_of(k));
          state <= S_TSUM;
        end
        S_TSUM: begin
          term <= quo;
          sum  <= k[0] ? sum - $signed({3'b000, quo}) : sum + $signed({3'b000, quo});
          k    <= k + 4'd1;
          if (k + 4'd1 == TAYLOR_TERMS) begin
            cnt   <= '0;
            state <= S_EXPM;
          end else begin
            state <= S_TMUL;
          end
        end
        S_EXPM: begin
          // The first visit turns the series sum into g.
          if (k != 4'd0) begin
            g <= sum[35] ? '0 : sum[32:0];
            k <= 4'd0;
          end else if (cnt < {1'b0, ip}) begin
            g   <= 33'((65'(g) * 65'(EXP_M1_Q32)) >> 32);
            cnt <= cnt + 6'd1;
          end else begin
            state <= S_FIN1;
          end
        end
        S_FIN1: begin
          p1    <= 39'(g * ({1'b0, ip} + 6'd1));
          state <= S_FIN2;
        end
        S_FIN2: begin
          p2    <= 33'((65'(g) * 65'(x)) >> 32);
          state <= S_FIN3;
        end
        S_FIN3: begin
          kval  <= (val > 24'(KVAL_ONE)) ? KVAL_ONE : val[16:0];
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || pop) begin
            kernel_value <= kval;
            saturated    <= sat;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### src/matern32_kernel_eval.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// matern32_kernel_eval
// Matern 3/2 kernel for one pair of points, one coordinate per transaction.
// ---------------------------------------------------------------------------
// Each input transaction passes through the front end's steps (difference,
// scale multiply, square, accumulate), and the front end takes no new
// dimension until the accumulate step is done; for the transaction marked
// last_dim that step waits while the queue is full. That transaction hands
// the pair's sum over a two-entry queue to the back end, which runs 32
// square-root steps, 13 series terms (each a multiply, a reciprocal multiply
// that divides by the term index, and the add), up to 31 multiplies by e^-1
// and a short final product; a far distance skips all but the square root.
// The front end keeps accumulating the next pair while the back end works,
// and a finished result waits in its own register until popped.
module matern32_kernel_eval import m32k_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [31:0] coord_a,
  input  logic [31:0] coord_b,
  input  logic [23:0] inv_lengthscale,
  input  logic        last_dim,
  output logic        empty,
  input  logic        pop,
  output logic [16:0] kernel_value,
  output logic        saturated
);

  pair_t f_data;
  pair_t b_data;
  logic  f_push;
  logic  q_full;
  logic  q_empty;
  logic  b_pop;

  // Front end: accumulation.
  m32k_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk, .rst, .push, .full, .coord_a, .coord_b, .inv_lengthscale, .last_dim,
    .q_push(f_push), .q_data(f_data), .q_full
  );

  // Queue between the two halves.
  m32k_queue u_queue (
    .clk, .rst, .wr(f_push), .wr_data(f_data), .q_full,
    .rd(b_pop), .rd_data(b_data), .q_empty
  );

  // Back end: kernel evaluation.
  m32k_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst, .q_empty, .q_data(b_data), .q_pop(b_pop),
    .empty, .pop, .kernel_value, .saturated
  );

  // The front end never hands a pair to a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) f_push |-> !q_full)
    else $error("pair pushed into full queue");

  // The back end never takes a pair from an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) b_pop |-> !q_empty)
    else $error("pair taken from empty queue");

  // A shown result never exceeds 1.0.
  a_kval_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (kernel_value <= KVAL_ONE))
    else $error("kernel value above one");

endmodule

### tb/tb_matern32_kernel_eval.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_matern32_kernel_eval
// Self-checking testbench for the Matern 3/2 kernel evaluator.
// ---------------------------------------------------------------------------
// A short table of directed dimensions (zero distance, zero lengthscale,
// saturating differences, far distances) runs first. Random pairs follow
// under four handshake pressure phases. A bit-exact kernel predictor
// computes the expected results of all but typed rows, and each popped
// result is compared field by field against the oldest expected one.
// ---------------------------------------------------------------------------
module tb_matern32_kernel_eval;
  import m32k_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int RAND_ITEMS = 1880;
  localparam longint CYCLE_LIMIT = 4000000;
  localparam int BACKEND_CYCLES = 700;

  typedef struct {
    logic [16:0] kval;
    logic        sat;
  } kernel_res_t;

  typedef struct {
    logic [31:0] a;
    logic [31:0] b;
    logic [23:0] inv;
    logic        last;
    bit          typed;
    logic [16:0] kval;
    logic        sat;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [31:0] coord_a = '0;
  logic [31:0] coord_b = '0;
  logic [23:0] inv_lengthscale = '0;
  logic        last_dim = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [16:0] kernel_value;
  logic        saturated;

  // Predictor state: running squared distance of the open pair.
  logic [63:0] dist_acc = '0;
  logic        dist_sat = 1'b0;

  kernel_res_t kernel_q[$];
  int          err_cnt = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          sat_results = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_cycles = 0;
  longint      cycle_cnt = 0;

  matern32_kernel_eval u_dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .coord_a(coord_a), .coord_b(coord_b), .inv_lengthscale(inv_lengthscale),
    .last_dim(last_dim), .empty(empty), .pop(pop),
    .kernel_value(kernel_value), .saturated(saturated)
  );

  always #1 clk = ~clk;

  // Cycle limit guards against a hung block.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("matern32_kernel_eval regression: fail");
      $finish;
    end
  end

  // Integer square root, floor.
  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // exp(-x) for a Q32 fraction, truncated Taylor series.
  function automatic logic [63:0] exp_neg_q32(logic [63:0] x);
    longint      sum;
    logic [63:0] term;
    sum = 64'sd1 << 32;
    term = 64'd1 << 32;
    for (int k = 1; k < TAYLOR_TERMS; k++) begin
      term = ((term * x) >> 32) / k;
      if (k % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    return 64'(sum);
  endfunction

  // Kernel value (1+t)exp(-t) from a squared distance sum.
  function automatic logic [16:0] matern_of(logic [63:0] acc);
    logic [63:0] tri_acc, t, t32, ip, g, hi, lo, val;
    tri_acc = (acc > 64'hFFFF_FFFF_FFFF_FFFF / 3) ? '1 : acc * 3;
    t = int_sqrt(tri_acc);
    if ((t >> FRAC) >= T_LIMIT_INT) return '0;
    t32 = t << (32 - FRAC);
    ip = t32 >> 32;
    g = exp_neg_q32(t32 & 64'hFFFF_FFFF);
    for (int i = 0; i < int'(ip); i++) g = (g * EXP_M1_Q32) >> 32;
    hi = ((64'd1 << 32) + t32) >> 32;
    lo = ((64'd1 << 32) + t32) & 64'hFFFF_FFFF;
    val = ((g * hi) + ((g * lo) >> 32)) >> 16;
    if (val > KVAL_ONE) val = KVAL_ONE;
    return val[16:0];
  endfunction

  // Fold one accepted dimension into the predictor; returns 1 with a result.
  function automatic bit add_dimension(logic [31:0] a, logic [31:0] b,
                                       logic [23:0] inv, logic last,
                                       output kernel_res_t res);
    longint      sa, sb;
    logic [63:0] mag, s, sq;
    sa = longint'($signed(a));
    sb = longint'($signed(b));
    mag = (sa >= sb) ? 64'(sa - sb) : 64'(sb - sa);
    s = (mag * inv) >> FRAC;
    if (s > 64'hFFFF_FFFF) begin
      sq = '1;
      dist_sat = 1'b1;
    end else begin
      sq = s * s;
    end
    if (dist_acc > ~sq) begin
      dist_acc = '1;
      dist_sat = 1'b1;
    end else begin
      dist_acc = dist_acc + sq;
    end
    res.kval = '0;
    res.sat = 1'b0;
    if (!last) return 0;
    res.kval = matern_of(dist_acc);
    res.sat = dist_sat;
    dist_acc = '0;
    dist_sat = 1'b0;
    return 1;
  endfunction

  // Offer one dimension until accepted; a last dimension records its pair's expected result.
  task automatic send_dim(logic [31:0] a, logic [31:0] b, logic [23:0] inv,
                          logic last, bit typed = 0, logic [16:0] kv = '0,
                          logic sat = 1'b0);
    kernel_res_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    coord_a <= a;
    coord_b <= b;
    inv_lengthscale <= inv;
    last_dim <= last;
    do @(posedge clk); while (full);
    items_sent++;
    if (add_dimension(a, b, inv, last, res)) begin
      if (typed) begin
        res.kval = kv;
        res.sat = sat;
      end
      kernel_q.push_back(res);
    end
  endtask

  task automatic go_quiet();
    push <= 1'b0;
    @(posedge clk);
  endtask

  // Random pair: mostly small, well-formed distances; some full-range noise.
  task automatic send_random_pair(bit one_dim);
    int          ndim, mode;
    logic [31:0] a, b;
    logic [23:0] inv;
    ndim = one_dim ? 1 : (($urandom_range(9) == 0) ? $urandom_range(5, 12)
                                                   : $urandom_range(1, 4));
    for (int d = 0; d < ndim; d++) begin
      mode = $urandom_range(99);
      if (mode < 70) begin
        a = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        b = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        inv = $urandom_range(0, 24'h02_0000);
      end else if (mode < 85) begin
        a = $urandom;
        b = $urandom;
        inv = $urandom_range(0, 24'hFF_FFFF);
      end else begin
        a = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
        b = $urandom;
        inv = $urandom_range(0, 24'h00_0400);
      end
      // A stray early last splits a sequence now and then.
      send_dim(a, b, inv, (d == ndim - 1) || ($urandom_range(49) == 0));
    end
  endtask

  // Result side: compares each popped transaction and drives pop.
  always @(posedge clk) begin
    kernel_res_t exp_r;
    if (!rst && pop && !empty) begin
      results_seen++;
      if (kernel_q.size() == 0) begin
        $error("unexpected result kernel_value=%0d saturated=%0b",
               kernel_value, saturated);
        err_cnt++;
      end else begin
        exp_r = kernel_q.pop_front();
        if (exp_r.sat) sat_results++;
        if (kernel_value !== exp_r.kval) begin
          $error("kernel_value expected %0d actual %0d", exp_r.kval, kernel_value);
          err_cnt++;
        end
        if (saturated !== exp_r.sat) begin
          $error("saturated expected %0b actual %0b", exp_r.sat, saturated);
          err_cnt++;
        end
      end
    end
    if (rst) begin
      pop <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Directed dimensions; typed rows carry results that are obvious by hand.
  dir_row_t dir_rows[16] = '{
    '{32'h0000_0000, 32'h0000_0000, 24'h01_0000, 1'b1, 1, 17'd65536, 1'b0},
    '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFF_FFFF, 1'b1, 1, 17'd65536, 1'b0},
    '{32'h7FFF_FFFF, 32'h8000_0000, 24'hFF_FFFF, 1'b1, 1, 17'd0, 1'b1},
    '{32'h8000_0000, 32'h7FFF_FFFF, 24'h00_0000, 1'b1, 1, 17'd65536, 1'b0},
    '{32'h0001_0000, 32'h0000_0000, 24'h01_0000, 1'b1, 0, 17'd0, 1'b0},
    '{32'hFFFF_8000, 32'h0000_4000, 24'h00_C000, 1'b0, 0, 17'd0, 1'b0},
    '{32'h0000_2000, 32'hFFFF_F000, 24'h02_0000, 1'b1, 0, 17'd0, 1'b0},
    '{32'hFFFF_FFFF, 32'h0000_0000, 24'h01_0000, 1'b0, 0, 17'd0, 1'b0},
    '{32'h7FFF_FFFF, 32'hFFFF_FFFF, 24'h00_FFFF, 1'b0, 0, 17'd0, 1'b0},
    '{32'h0000_0000, 32'h8000_0001, 24'h00_FFFF, 1'b1, 0, 17'd0, 1'b0},
    '{32'h0000_0000, 32'h0000_0000, 24'h00_0000, 1'b1, 1, 17'd65536, 1'b0},
    '{32'h0013_0000, 32'h0000_0000, 24'h01_0000, 1'b1, 1, 17'd0, 1'b0},
    '{32'h0012_0000, 32'h0000_0000, 24'h01_0000, 1'b1, 0, 17'd0, 1'b0},
    '{32'h0000_0001, 32'h0000_0000, 24'h00_0001, 1'b1, 0, 17'd0, 1'b0},
    '{32'h5555_5555, 32'hAAAA_AAAA, 24'hAA_AAAA, 1'b1, 0, 17'd0, 1'b0},
    '{32'hAAAA_AAAA, 32'h5555_5555, 24'h55_5555, 1'b1, 0, 17'd0, 1'b0}
  };

  // Stimulus sequence.
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i])
      send_dim(dir_rows[i].a, dir_rows[i].b, dir_rows[i].inv, dir_rows[i].last,
               dir_rows[i].typed, dir_rows[i].kval, dir_rows[i].sat);
    go_quiet();
    wait (kernel_q.size() == 0);

    // Hold off the receiver while one-dimension pairs keep arriving.
    hold_cycles = 8000;
    repeat (12) send_random_pair(1);
    go_quiet();
    wait (kernel_q.size() == 0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 83; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 83; end
        default: begin send_idle_pct = 6; stall_pct = 6; end
      endcase
      while (items_sent < 40 + (ph + 1) * RAND_ITEMS / 4) send_random_pair(0);
      go_quiet();
      // The sender pauses until the block has drained.
      wait (kernel_q.size() == 0);
    end

    repeat (BACKEND_CYCLES) @(posedge clk);
    $display("Sent %0d dimensions and checked %0d kernel results (%0d saturated)",
             items_sent, results_seen, sat_results);
    $display("across four handshake pressure phases and one long receiver hold.");
    if (err_cnt == 0 && kernel_q.size() == 0) begin
      $display("matern32_kernel_eval regression: pass");
    end else begin
      $display("matern32_kernel_eval regression: fail");
    end
    $finish;
  end

endmodule

### matern32_kernel_eval.f
src/m32k_pkg.sv
src/m32k_front.sv
src/m32k_queue.sv
src/m32k_back.sv
src/matern32_kernel_eval.sv
tb/tb_matern32_kernel_eval.sv
